### hdl/m3inv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3inv_pkg
// Shared types and constants for the 3x3 matrix inverse pipeline.
// ----------------------------------------------------------------------------
package m3inv_pkg;

  localparam int unsigned ElemW  = 16;  // Q4.12 input element
  localparam int unsigned ResW   = 32;  // Q16.16 result element
  localparam int unsigned CofW   = 33;  // signed cofactor
  localparam int unsigned MagW   = 32;  // cofactor magnitude
  localparam int unsigned DetW   = 50;  // signed determinant
  localparam int unsigned DenW   = 48;  // determinant magnitude
  localparam int unsigned QuoW   = 33;  // quotient bits, twice the final scale
  localparam int unsigned PreW   = 4;   // low magnitude bits fed into the divider

  typedef struct packed {
    logic signed [ElemW-1:0] a00;
    logic signed [ElemW-1:0] a01;
    logic signed [ElemW-1:0] a02;
    logic signed [ElemW-1:0] a10;
    logic signed [ElemW-1:0] a11;
    logic signed [ElemW-1:0] a12;
    logic signed [ElemW-1:0] a20;
    logic signed [ElemW-1:0] a21;
    logic signed [ElemW-1:0] a22;
  } m3inv_in_t;

  typedef struct packed {
    logic signed [ResW-1:0] r00;
    logic signed [ResW-1:0] r01;
    logic signed [ResW-1:0] r02;
    logic signed [ResW-1:0] r10;
    logic signed [ResW-1:0] r11;
    logic signed [ResW-1:0] r12;
    logic signed [ResW-1:0] r20;
    logic signed [ResW-1:0] r21;
    logic signed [ResW-1:0] r22;
    logic                   singular;
  } m3inv_out_t;

  // per-lane flags that ride along with the divider
  typedef struct packed {
    logic neg;   // result sign
    logic ovf;   // quotient too large, saturate
    logic zero;  // determinant is zero
  } m3inv_flags_t;

endpackage

### hdl/m3inv_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3inv_div
// Pipelined restoring divider, one quotient bit per stage. Produces
// floor(mag * 2^29 / den) for inputs flagged as not overflowing.
// ----------------------------------------------------------------------------
module m3inv_div
  import m3inv_pkg::*;
(
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [MagW-1:0]   mag_i,
  input  logic [DenW-1:0]   den_i,
  input  m3inv_flags_t      flags_i,
  output logic [QuoW-1:0]   quo_o,
  output m3inv_flags_t      flags_o
);

  logic [DenW-1:0]   rem_q   [QuoW];
  logic [QuoW-1:0]   quo_q   [QuoW];
  logic [DenW-1:0]   den_q   [QuoW];
  logic [PreW-1:0]   lo_q    [QuoW];
  m3inv_flags_t      flg_q   [QuoW];

  for (genvar s = 0; s < QuoW; s++) begin : g_stage
    logic [DenW-1:0]   rem_in;
    logic [QuoW-1:0]   quo_in;
    logic [DenW-1:0]   den_in;
    logic [PreW-1:0]   lo_in;
    m3inv_flags_t      flg_in;
    logic              bit_in;
    logic [DenW:0]     trial;
    logic [DenW:0]     diff;

    if (s == 0) begin : g_first
      // top bits of mag * 2^29 above the quotient range
      assign rem_in = DenW'(mag_i >> PreW);
      assign quo_in = '0;
      assign den_in = den_i;
      assign lo_in  = mag_i[PreW-1:0];
      assign flg_in = flags_i;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign quo_in = quo_q[s-1];
      assign den_in = den_q[s-1];
      assign lo_in  = lo_q[s-1];
      assign flg_in = flg_q[s-1];
    end

    if (s < PreW) begin : g_lo
      assign bit_in = lo_in[PreW-1-s];
    end else begin : g_zero
      assign bit_in = 1'b0;
    end

    assign trial = {rem_in, bit_in};
    assign diff  = trial - {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!diff[DenW]) begin
          rem_q[s] <= diff[DenW-1:0];
        end else begin
          rem_q[s] <= trial[DenW-1:0];
        end
        quo_q[s] <= {quo_in[QuoW-2:0], ~diff[DenW]};
        den_q[s] <= den_in;
        lo_q[s]  <= lo_in;
        flg_q[s] <= flg_in;
      end
    end
  end

  assign quo_o   = quo_q[QuoW-1];
  assign flags_o = flg_q[QuoW-1];

endmodule

### hdl/matrix3x3_inverse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix3x3_inverse
// Adjugate-based 3x3 matrix inverse, Q4.12 in, saturated Q16.16 out.
// ----------------------------------------------------------------------------
// Takes one matrix per clock while out_ready_i does not stall the output. Five
// stages form the products, cofactors and determinant and split off signs;
// nine parallel dividers then spend 33 stages, one quotient bit each, on
// cofactor / determinant; a final stage rounds to nearest (ties away from
// zero), saturates and applies the sign. A zero determinant raises singular
// and zeroes every element. The whole pipeline holds while a finished result
// waits on out_ready_i, so nothing is dropped or repeated under stalls.
module matrix3x3_inverse
  import m3inv_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  m3inv_in_t   in_req_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output m3inv_out_t  out_rsp_o
);

  localparam int unsigned PreStages = 5;
  localparam int unsigned Depth     = PreStages + QuoW + 1;

  function automatic logic signed [2*ElemW-1:0] mul_ee(
    input logic signed [ElemW-1:0] x,
    input logic signed [ElemW-1:0] y
  );
    logic signed [2*ElemW-1:0] xe;
    logic signed [2*ElemW-1:0] ye;
    xe = (2*ElemW)'(x);
    ye = (2*ElemW)'(y);
    return xe * ye;
  endfunction

  function automatic logic signed [ElemW+CofW-1:0] mul_ec(
    input logic signed [ElemW-1:0] x,
    input logic signed [CofW-1:0]  y
  );
    logic signed [ElemW+CofW-1:0] xe;
    logic signed [ElemW+CofW-1:0] ye;
    xe = (ElemW+CofW)'(x);
    ye = (ElemW+CofW)'(y);
    return xe * ye;
  endfunction

  logic              adv;
  logic [Depth-1:0]  vld_q;

  assign out_valid_o = vld_q[Depth-1];
  assign adv         = ~out_valid_o | out_ready_i;
  assign in_ready_o  = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[Depth-2:0], in_valid_i};
    end
  end

  // stage 1: products
  logic signed [ElemW-1:0]     a [9];
  logic signed [2*ElemW-1:0]   pa_d [9], pb_d [9], pa_q [9], pb_q [9];
  logic signed [ElemW-1:0]     r0_q [3];

  assign a[0] = in_req_i.a00;
  assign a[1] = in_req_i.a01;
  assign a[2] = in_req_i.a02;
  assign a[3] = in_req_i.a10;
  assign a[4] = in_req_i.a11;
  assign a[5] = in_req_i.a12;
  assign a[6] = in_req_i.a20;
  assign a[7] = in_req_i.a21;
  assign a[8] = in_req_i.a22;

  always_comb begin
    pa_d[0] = mul_ee(a[4], a[8]);  pb_d[0] = mul_ee(a[5], a[7]);
    pa_d[1] = mul_ee(a[2], a[7]);  pb_d[1] = mul_ee(a[1], a[8]);
    pa_d[2] = mul_ee(a[1], a[5]);  pb_d[2] = mul_ee(a[2], a[4]);
    pa_d[3] = mul_ee(a[5], a[6]);  pb_d[3] = mul_ee(a[3], a[8]);
    pa_d[4] = mul_ee(a[0], a[8]);  pb_d[4] = mul_ee(a[2], a[6]);
    pa_d[5] = mul_ee(a[2], a[3]);  pb_d[5] = mul_ee(a[0], a[5]);
    pa_d[6] = mul_ee(a[3], a[7]);  pb_d[6] = mul_ee(a[4], a[6]);
    pa_d[7] = mul_ee(a[1], a[6]);  pb_d[7] = mul_ee(a[0], a[7]);
    pa_d[8] = mul_ee(a[0], a[4]);  pb_d[8] = mul_ee(a[1], a[3]);
  end

  // stage 2: cofactors
  logic signed [CofW-1:0]  cof2_q [9];
  logic signed [ElemW-1:0] r0b_q [3];

  // stage 3: determinant terms
  logic signed [ElemW+CofW-1:0] dp_q [3];
  logic signed [CofW-1:0]       cof3_q [9];

  // stage 4: determinant
  logic signed [DetW-1:0]  det_q;
  logic signed [CofW-1:0]  cof4_q [9];

  // stage 5: magnitudes and flags
  logic [DetW-1:0]   det_abs;
  logic [MagW-1:0]   mag_q [9];
  logic [DenW-1:0]   den_q;
  m3inv_flags_t      flg_q [9];

  assign det_abs = det_q[DetW-1] ? DetW'(-det_q) : DetW'(det_q);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 9; k++) begin
        logic [CofW-1:0] cabs;
        pa_q[k]   <= pa_d[k];
        pb_q[k]   <= pb_d[k];
        cof2_q[k] <= CofW'(pa_q[k]) - CofW'(pb_q[k]);
        cof3_q[k] <= cof2_q[k];
        cof4_q[k] <= cof3_q[k];
        cabs = cof4_q[k][CofW-1] ? CofW'(-cof4_q[k]) : CofW'(cof4_q[k]);
        mag_q[k]      <= cabs[MagW-1:0];
        flg_q[k].neg  <= cof4_q[k][CofW-1] ^ det_q[DetW-1];
        flg_q[k].zero <= (det_q == '0);
        flg_q[k].ovf  <= {(DenW+PreW-MagW)'(0), cabs[MagW-1:0]} >=
                         {det_abs[DenW-1:0], PreW'(0)};
      end
      for (int j = 0; j < 3; j++) begin
        r0_q[j]  <= a[j];
        r0b_q[j] <= r0_q[j];
      end
      dp_q[0] <= mul_ec(r0b_q[0], cof2_q[0]);
      dp_q[1] <= mul_ec(r0b_q[1], cof2_q[3]);
      dp_q[2] <= mul_ec(r0b_q[2], cof2_q[6]);
      det_q   <= DetW'(dp_q[0]) + DetW'(dp_q[1]) + DetW'(dp_q[2]);
      den_q   <= det_abs[DenW-1:0];
    end
  end

  // dividers and output stage
  logic [QuoW-1:0]          quo   [9];
  m3inv_flags_t             dflg  [9];
  logic signed [ResW-1:0]   res_q [9];
  logic                     sing_q;

  for (genvar k = 0; k < 9; k++) begin : g_lane
    logic [QuoW:0]   rnd;
    logic [ResW-1:0] mag;
    logic [ResW-1:0] res_d;

    m3inv_div u_div (
      .clk_i   (clk_i),
      .en_i    (adv),
      .mag_i   (mag_q[k]),
      .den_i   (den_q),
      .flags_i (flg_q[k]),
      .quo_o   (quo[k]),
      .flags_o (dflg[k])
    );

    // round half away from zero on the doubled quotient, clamp to 2^31
    assign rnd = ({1'b0, quo[k]} + (QuoW+1)'(1)) >> 1;
    assign mag = (dflg[k].ovf || (rnd >= (QuoW+1)'(1) << (ResW-1)))
                 ? ResW'(1) << (ResW-1) : rnd[ResW-1:0];

    always_comb begin
      if (dflg[k].zero) begin
        res_d = '0;
      end else if (dflg[k].neg) begin
        res_d = -mag;
      end else if (mag[ResW-1]) begin
        res_d = {1'b0, {(ResW-1){1'b1}}};
      end else begin
        res_d = mag;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        res_q[k] <= res_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sing_q <= dflg[0].zero;
    end
  end

  assign out_rsp_o.r00      = res_q[0];
  assign out_rsp_o.r01      = res_q[1];
  assign out_rsp_o.r02      = res_q[2];
  assign out_rsp_o.r10      = res_q[3];
  assign out_rsp_o.r11      = res_q[4];
  assign out_rsp_o.r12      = res_q[5];
  assign out_rsp_o.r20      = res_q[6];
  assign out_rsp_o.r21      = res_q[7];
  assign out_rsp_o.r22      = res_q[8];
  assign out_rsp_o.singular = sing_q;

  // singular results carry zeros in r00, r11 and r22
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.singular |->
      out_rsp_o.r00 == '0 && out_rsp_o.r11 == '0 && out_rsp_o.r22 == '0)
    else $error("singular result with nonzero element");

  // a stalled pipeline keeps every occupancy bit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(vld_q))
    else $error("pipeline moved during stall");

  // an accepted request enters the first stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> vld_q[0])
    else $error("accepted request lost");

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Streams random and corner-case 3x3 matrices into the inverse pipeline and
// checks every returned inverse against a Q16.16 adjugate predictor.
// ----------------------------------------------------------------------------
module tb_top;
  import m3inv_pkg::*;

  localparam int unsigned NumRandom = 1350;
  localparam int unsigned MaxCycles = 400000;
  localparam int unsigned Latency   = 39;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  m3inv_in_t  in_req_i = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  m3inv_out_t out_rsp_o;

  m3inv_in_t  pending_mats[$];
  m3inv_out_t inverse_q[$];
  int unsigned mismatches = 0;
  int unsigned cycle_cnt = 0;
  bit          hold_off = 1'b0;
  bit          quiet = 1'b0;
  bit          in_taken = 1'b0;

  matrix3x3_inverse dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_req_i,
    .out_valid_o, .out_ready_i, .out_rsp_o
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // round c*2^28/d to nearest, ties away from zero, saturate to 32 bits
  function automatic logic [31:0] q16_quotient(longint c, longint d);
    logic        neg;
    logic [63:0] cm, dm, num, q;
    neg = (c < 0) != (d < 0);
    cm  = (c < 0) ? -c : c;
    dm  = (d < 0) ? -d : d;
    num = cm << 28;
    q   = (2 * num + dm) / (2 * dm);
    if (neg) begin
      if (q >= 64'h8000_0000) return 32'h8000_0000;
      return 32'(-q);
    end
    if (q > 64'h7fff_ffff) return 32'h7fff_ffff;
    return q[31:0];
  endfunction

  function automatic m3inv_out_t invert_matrix(m3inv_in_t m);
    longint     e[9];
    longint     cof[9];
    longint     det;
    m3inv_out_t r;
    e = '{m.a00, m.a01, m.a02, m.a10, m.a11, m.a12, m.a20, m.a21, m.a22};
    cof[0] = e[4] * e[8] - e[5] * e[7];
    cof[1] = e[2] * e[7] - e[1] * e[8];
    cof[2] = e[1] * e[5] - e[2] * e[4];
    cof[3] = e[5] * e[6] - e[3] * e[8];
    cof[4] = e[0] * e[8] - e[2] * e[6];
    cof[5] = e[2] * e[3] - e[0] * e[5];
    cof[6] = e[3] * e[7] - e[4] * e[6];
    cof[7] = e[1] * e[6] - e[0] * e[7];
    cof[8] = e[0] * e[4] - e[1] * e[3];
    det = e[0] * cof[0] + e[1] * cof[3] + e[2] * cof[6];
    r = '0;
    if (det == 0) begin
      r.singular = 1'b1;
      return r;
    end
    r.r00 = q16_quotient(cof[0], det);
    r.r01 = q16_quotient(cof[1], det);
    r.r02 = q16_quotient(cof[2], det);
    r.r10 = q16_quotient(cof[3], det);
    r.r11 = q16_quotient(cof[4], det);
    r.r12 = q16_quotient(cof[5], det);
    r.r20 = q16_quotient(cof[6], det);
    r.r21 = q16_quotient(cof[7], det);
    r.r22 = q16_quotient(cof[8], det);
    return r;
  endfunction

  function automatic m3inv_in_t diag_matrix(logic [15:0] d0, logic [15:0] d1,
                                            logic [15:0] d2);
    m3inv_in_t m;
    m = '0;
    m.a00 = d0;
    m.a11 = d1;
    m.a22 = d2;
    return m;
  endfunction

  // mostly small-ish well-conditioned values, some full-range noise and extremes
  function automatic logic [15:0] rand_elem(int unsigned mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(0, 16384)) - 8192);
      2: return 16'($signed($urandom_range(0, 1024)) - 512);
      default: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
    endcase
  endfunction

  // idle about 15 percent of the time, except in quiet stretches
  function automatic bit idle_now();
    return !quiet && ($urandom_range(0, 99) < 15);
  endfunction

  // driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_taken) begin
        // hold request until accepted
      end else if (pending_mats.size() > 0 && !hold_off && !idle_now()) begin
        in_req_i   <= pending_mats.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
      out_ready_i <= !idle_now();
    end
  end

  always @(posedge clk_i) begin
    in_taken <= rst_ni && in_valid_i && in_ready_o;
    if (rst_ni && in_valid_i && in_ready_o) begin
      inverse_q.push_back(invert_matrix(in_req_i));
    end
  end

  // monitor
  always @(posedge clk_i) begin
    m3inv_out_t exp_rsp;
    cycle_cnt <= cycle_cnt + 1;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (inverse_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_rsp_o);
      end else begin
        exp_rsp = inverse_q.pop_front();
        if (exp_rsp !== out_rsp_o) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch singular exp %b act %b", exp_rsp.singular, out_rsp_o.singular);
            $display("  r00..r22 exp %h", exp_rsp[288:1]);
            $display("  r00..r22 act %h", out_rsp_o[288:1]);
          end
        end
      end
    end
    if (cycle_cnt > MaxCycles) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    m3inv_in_t m;
    int unsigned mode;
    // directed: identity, extremes, singular cases
    pending_mats.push_back(diag_matrix(16'h1000, 16'h1000, 16'h1000));
    pending_mats.push_back(diag_matrix(16'h7fff, 16'h7fff, 16'h7fff));
    pending_mats.push_back(diag_matrix(16'h8000, 16'h8000, 16'h8000));
    pending_mats.push_back(diag_matrix(16'h0001, 16'h0001, 16'h0001));
    pending_mats.push_back(diag_matrix(16'hffff, 16'h0001, 16'hffff));
    pending_mats.push_back(diag_matrix(16'h0001, 16'h7fff, 16'h8000));
    pending_mats.push_back('0);
    pending_mats.push_back({9{16'h7fff}});
    pending_mats.push_back({9{16'h8000}});
    pending_mats.push_back({9{16'hffff}});
    m = diag_matrix(16'h2000, 16'h2000, 16'h2000);
    m.a01 = 16'h1000;
    pending_mats.push_back(m);
    m = diag_matrix(16'h0003, 16'h0003, 16'h0003);
    m.a12 = 16'h0001;
    pending_mats.push_back(m);
    m = '0;
    m.a01 = 16'h1000; m.a12 = 16'h1000; m.a20 = 16'h1000;
    pending_mats.push_back(m);
    m = diag_matrix(16'h1000, 16'h1000, 16'h0000);
    pending_mats.push_back(m);
    m = {16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
         16'h7fff, 16'h8000, 16'h0001};
    pending_mats.push_back(m);
    pending_mats.push_back(diag_matrix(16'h0003, 16'h0006, 16'h7ffd));
    repeat (11) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
    for (int i = 0; i < NumRandom; i++) begin
      mode = $urandom_range(0, 9);
      mode = (mode < 3) ? 0 : (mode < 6) ? 1 : (mode < 9) ? 2 : 3;
      for (int k = 0; k < 9; k++) m[16*k +: 16] = rand_elem(mode);
      // occasionally make two rows equal to force a singular matrix
      if ($urandom_range(0, 19) == 0) m[143:96] = m[95:48];
      pending_mats.push_back(m);
      if (i == 600) begin
        wait (pending_mats.size() == 0);
        hold_off = 1'b1;
        wait (inverse_q.size() == 0 && !in_valid_i);
        @(negedge clk_i) hold_off = 1'b0;
      end
      // quiet stretch covers the requests queued between these two points
      if (i == 900) begin
        wait (pending_mats.size() == 0);
        quiet = 1'b1;
      end
      if (i == 1100) begin
        wait (pending_mats.size() == 0);
        quiet = 1'b0;
      end
    end
    wait (pending_mats.size() == 0 && !in_valid_i);
    wait (inverse_q.size() == 0);
    repeat (Latency + 10) @(posedge clk_i);
    if (mismatches == 0 && inverse_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
